FILE: hdl/sfd_pkg.sv
`default_nettype none

package sfd_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int DELAY_DEPTH = 65536;
    localparam int ADDR_BITS   = $clog2(DELAY_DEPTH);

    localparam int DELAY_BITS  = 16;
    localparam int COEF_BITS   = 16;
    localparam int WET_BITS    = 17;
    localparam int FRAC_BITS   = 16;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 17;

    localparam logic [CFG_IDX_BITS-1:0] REG_DELAY_SAMPLES  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_FILTER_COEFF   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_FEEDBACK_GAIN  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_WET_MIX        = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_PING_PONG      = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_EFFECT_ENABLED = 3'd5;

    localparam logic [WET_BITS-1:0] UNITY = WET_BITS'(1 << FRAC_BITS);

    localparam int MUL_A_BITS = SAMPLE_BITS + 1;
    localparam int MUL_B_BITS = WET_BITS + 1;
    localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;
    localparam int SUM_BITS   = PROD_BITS + 1;

    localparam int MUL_OPS   = 8;
    localparam int STEP_BITS = $clog2(MUL_OPS + 1);

    typedef struct packed {
        logic [DELAY_BITS-1:0] delay_samples;
        logic [COEF_BITS-1:0]  filter_coeff;
        logic [COEF_BITS-1:0]  feedback_gain;
        logic [WET_BITS-1:0]   wet_mix;
        logic                  ping_pong;
        logic                  effect_enabled;
    } cfg_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_FILT_L,
        OP_FILT_R,
        OP_DRY_L,
        OP_FB_L,
        OP_WET_L,
        OP_FB_R,
        OP_DRY_R,
        OP_WET_R
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_WRITE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic capture_in;
        logic mem_rd;
        op_t  mul_op;
        op_t  post_op;
        logic mem_wr;
        logic load_out;
    } cmd_t;

endpackage

`default_nettype wire

FILE: hdl/sfd_cfg.sv
`default_nettype none

module sfd_cfg (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire  [sfd_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  wire  [sfd_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    output sfd_pkg::cfg_t                        cfg
);
    import sfd_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.delay_samples  <= DELAY_BITS'(1);
            cfg_reg.filter_coeff   <= '0;
            cfg_reg.feedback_gain  <= '0;
            cfg_reg.wet_mix        <= '0;
            cfg_reg.ping_pong      <= 1'b0;
            cfg_reg.effect_enabled <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_DELAY_SAMPLES:  cfg_reg.delay_samples  <= cfg_data[DELAY_BITS-1:0];
                REG_FILTER_COEFF:   cfg_reg.filter_coeff   <= cfg_data[COEF_BITS-1:0];
                REG_FEEDBACK_GAIN:  cfg_reg.feedback_gain  <= cfg_data[COEF_BITS-1:0];
                REG_WET_MIX:        cfg_reg.wet_mix        <= cfg_data[WET_BITS-1:0];
                REG_PING_PONG:      cfg_reg.ping_pong      <= cfg_data[0];
                REG_EFFECT_ENABLED: cfg_reg.effect_enabled <= cfg_data[0];
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: hdl/sfd_ctrl.sv
`default_nettype none

module sfd_ctrl (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  wire                 out_stall,
    input  wire                 effect_enabled,
    output sfd_pkg::cmd_t       cmd
);
    import sfd_pkg::*;

    state_t               state_reg, state_next;
    logic [STEP_BITS-1:0] step_reg, step_next;
    logic                 out_valid_reg, out_valid_next;

    function automatic op_t op_at(input logic [STEP_BITS-1:0] i);
        op_t op;
        case (i)
            STEP_BITS'(0): op = OP_FILT_L;
            STEP_BITS'(1): op = OP_FILT_R;
            STEP_BITS'(2): op = OP_DRY_L;
            STEP_BITS'(3): op = OP_FB_L;
            STEP_BITS'(4): op = OP_WET_L;
            STEP_BITS'(5): op = OP_FB_R;
            STEP_BITS'(6): op = OP_DRY_R;
            STEP_BITS'(7): op = OP_WET_R;
            default:       op = OP_NONE;
        endcase
        return op;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        cmd            = '0;
        cmd.mul_op     = OP_NONE;
        cmd.post_op    = OP_NONE;
        in_stall       = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture_in = 1'b1;
                    state_next     = effect_enabled ? ST_READ : ST_DONE;
                end
            end
            ST_READ:
            begin
                cmd.mem_rd = 1'b1;
                step_next  = '0;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul_op = op_at(step_reg);
                if (step_reg != '0)
                    cmd.post_op = op_at(step_reg - STEP_BITS'(1));
                if (step_reg == STEP_BITS'(MUL_OPS))
                    state_next = ST_WRITE;
                else
                    step_next = step_reg + STEP_BITS'(1);
            end
            ST_WRITE:
            begin
                cmd.mem_wr = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

FILE: hdl/sfd_dp.sv
`default_nettype none

module sfd_dp (
    input  wire                                         clk,
    input  wire                                         rst_n,
    input  wire  sfd_pkg::cfg_t                         cfg,
    input  wire  sfd_pkg::cmd_t                         cmd,
    input  wire  signed [sfd_pkg::SAMPLE_BITS-1:0]      left_in,
    input  wire  signed [sfd_pkg::SAMPLE_BITS-1:0]      right_in,
    output logic signed [sfd_pkg::SAMPLE_BITS-1:0]      left_out,
    output logic signed [sfd_pkg::SAMPLE_BITS-1:0]      right_out
);
    import sfd_pkg::*;

    logic [SAMPLE_BITS-1:0] mem_l [DELAY_DEPTH];
    logic [SAMPLE_BITS-1:0] mem_r [DELAY_DEPTH];

    logic [ADDR_BITS-1:0]          wp_reg;
    logic                          wrapped_reg;
    logic                          rd_valid_reg;
    logic [SAMPLE_BITS-1:0]        q_l_reg, q_r_reg;
    logic signed [SAMPLE_BITS-1:0] x_l_reg, x_r_reg;
    logic signed [SAMPLE_BITS-1:0] s_l_reg, s_r_reg;
    logic signed [SAMPLE_BITS-1:0] w_l_reg, w_r_reg;
    logic signed [SAMPLE_BITS-1:0] res_l_reg, res_r_reg;
    logic signed [SAMPLE_BITS-1:0] out_l_reg, out_r_reg;
    logic signed [PROD_BITS-1:0]   prod_reg, acc_reg;

    logic [ADDR_BITS-1:0]          delay_eff;
    logic [ADDR_BITS-1:0]          rd_addr;
    logic [ADDR_BITS:0]            rd_wide;
    logic [WET_BITS-1:0]           wet_eff, dry_eff;
    logic signed [SAMPLE_BITS-1:0] d_l, d_r;
    logic signed [MUL_A_BITS-1:0]  mul_a;
    logic signed [MUL_B_BITS-1:0]  mul_b;
    logic signed [SUM_BITS-1:0]    prod_rnd;
    logic signed [SUM_BITS-1:0]    mix_rnd;

    function automatic logic signed [SUM_BITS-1:0] rnd16(input logic signed [SUM_BITS-1:0] v);
        logic signed [SUM_BITS:0] t;
        t = (SUM_BITS+1)'(v) + (SUM_BITS+1)'(1 << (FRAC_BITS - 1));
        return SUM_BITS'(t >>> FRAC_BITS);
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] sat(input logic signed [SUM_BITS-1:0] v);
        logic signed [SUM_BITS-1:0] hi;
        logic signed [SUM_BITS-1:0] lo;
        hi = SUM_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
        lo = -hi - SUM_BITS'(1);
        if (v > hi)
            return SAMPLE_BITS'(hi);
        else if (v < lo)
            return SAMPLE_BITS'(lo);
        else
            return SAMPLE_BITS'(v);
    endfunction

    always_comb
    begin
        if (cfg.delay_samples == '0)
            delay_eff = ADDR_BITS'(1);
        else if (32'(cfg.delay_samples) > 32'(DELAY_DEPTH - 1))
            delay_eff = ADDR_BITS'(DELAY_DEPTH - 1);
        else
            delay_eff = ADDR_BITS'(cfg.delay_samples);

        if (wp_reg >= delay_eff)
            rd_wide = (ADDR_BITS+1)'(wp_reg) - (ADDR_BITS+1)'(delay_eff);
        else
            rd_wide = (ADDR_BITS+1)'(wp_reg) + (ADDR_BITS+1)'(DELAY_DEPTH)
                    - (ADDR_BITS+1)'(delay_eff);
        rd_addr = rd_wide[ADDR_BITS-1:0];

        wet_eff = (cfg.wet_mix > UNITY) ? UNITY : cfg.wet_mix;
        dry_eff = UNITY - wet_eff;

        d_l = rd_valid_reg ? signed'(q_l_reg) : '0;
        d_r = rd_valid_reg ? signed'(q_r_reg) : '0;

        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_op)
            OP_FILT_L:
            begin
                mul_a = MUL_A_BITS'(d_l) - MUL_A_BITS'(s_l_reg);
                mul_b = MUL_B_BITS'(cfg.filter_coeff);
            end
            OP_FILT_R:
            begin
                mul_a = MUL_A_BITS'(d_r) - MUL_A_BITS'(s_r_reg);
                mul_b = MUL_B_BITS'(cfg.filter_coeff);
            end
            OP_FB_L:
            begin
                mul_a = MUL_A_BITS'(cfg.ping_pong ? s_r_reg : s_l_reg);
                mul_b = MUL_B_BITS'(cfg.feedback_gain);
            end
            OP_FB_R:
            begin
                mul_a = MUL_A_BITS'(cfg.ping_pong ? s_l_reg : s_r_reg);
                mul_b = MUL_B_BITS'(cfg.feedback_gain);
            end
            OP_DRY_L:
            begin
                mul_a = MUL_A_BITS'(x_l_reg);
                mul_b = MUL_B_BITS'(dry_eff);
            end
            OP_DRY_R:
            begin
                mul_a = MUL_A_BITS'(x_r_reg);
                mul_b = MUL_B_BITS'(dry_eff);
            end
            OP_WET_L:
            begin
                mul_a = MUL_A_BITS'(s_l_reg);
                mul_b = MUL_B_BITS'(wet_eff);
            end
            OP_WET_R:
            begin
                mul_a = MUL_A_BITS'(s_r_reg);
                mul_b = MUL_B_BITS'(wet_eff);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase

        prod_rnd = rnd16(SUM_BITS'(prod_reg));
        mix_rnd  = rnd16(SUM_BITS'(acc_reg) + SUM_BITS'(prod_reg));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr)
        begin
            mem_l[wp_reg] <= w_l_reg;
            mem_r[wp_reg] <= w_r_reg;
        end
        if (cmd.mem_rd)
        begin
            q_l_reg <= mem_l[rd_addr];
            q_r_reg <= mem_r[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg       <= '0;
            wrapped_reg  <= 1'b0;
            rd_valid_reg <= 1'b0;
            s_l_reg      <= '0;
            s_r_reg      <= '0;
        end
        else
        begin
            if (cmd.mem_rd)
                rd_valid_reg <= wrapped_reg || (rd_addr < wp_reg);
            if (cmd.mem_wr)
            begin
                if (wp_reg == ADDR_BITS'(DELAY_DEPTH - 1))
                begin
                    wp_reg      <= '0;
                    wrapped_reg <= 1'b1;
                end
                else
                begin
                    wp_reg <= wp_reg + ADDR_BITS'(1);
                end
            end
            case (cmd.post_op)
                OP_FILT_L: s_l_reg <= sat(SUM_BITS'(s_l_reg) + prod_rnd);
                OP_FILT_R: s_r_reg <= sat(SUM_BITS'(s_r_reg) + prod_rnd);
                default:   s_l_reg <= s_l_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (cmd.capture_in)
        begin
            x_l_reg   <= left_in;
            x_r_reg   <= right_in;
            res_l_reg <= left_in;
            res_r_reg <= right_in;
        end
        case (cmd.post_op)
            OP_FB_L:  w_l_reg   <= sat(SUM_BITS'(x_l_reg) + prod_rnd);
            OP_FB_R:  w_r_reg   <= sat(SUM_BITS'(x_r_reg) + prod_rnd);
            OP_DRY_L: acc_reg   <= prod_reg;
            OP_DRY_R: acc_reg   <= prod_reg;
            OP_WET_L: res_l_reg <= sat(mix_rnd);
            OP_WET_R: res_r_reg <= sat(mix_rnd);
            default:  acc_reg   <= acc_reg;
        endcase
        if (cmd.load_out)
        begin
            out_l_reg <= res_l_reg;
            out_r_reg <= res_r_reg;
        end
    end

    assign left_out  = out_l_reg;
    assign right_out = out_r_reg;

endmodule

`default_nettype wire

FILE: hdl/stereo_feedback_delay.sv
`default_nettype none

// Stereo feedback delay with a one-pole lowpass in the echo path and optional
// ping-pong cross-feed. Each transaction carries one stereo sample pair and
// yields one output pair. With the effect enabled an item goes from acceptance
// to a loaded output: accept, delay line read, nine steps of the one shared
// multiplier for the eight products, delay line write, output load; in bypass
// it goes straight to output load. A new item is taken once the previous one
// has reached the output register, so a result waiting at the output does not
// block input. The delay lines need no clearing pass after reset: a fill flag
// marks entries not yet written since reset, and those read as zero. Write the
// configuration registers only while no transaction is in flight.
module stereo_feedback_delay (
    input  wire                                         clk,
    input  wire                                         rst_n,
    input  wire                                         in_valid,
    output logic                                        in_stall,
    input  wire  signed [sfd_pkg::SAMPLE_BITS-1:0]      left_in,
    input  wire  signed [sfd_pkg::SAMPLE_BITS-1:0]      right_in,
    output logic                                        out_valid,
    input  wire                                         out_stall,
    output logic signed [sfd_pkg::SAMPLE_BITS-1:0]      left_out,
    output logic signed [sfd_pkg::SAMPLE_BITS-1:0]      right_out,
    input  wire                                         cfg_valid,
    output logic                                        cfg_ready,
    input  wire  [sfd_pkg::CFG_IDX_BITS-1:0]            cfg_index,
    input  wire  [sfd_pkg::CFG_DATA_BITS-1:0]           cfg_data
);
    import sfd_pkg::*;

    cfg_t cfg;
    cmd_t cmd;

    sfd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sfd_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .effect_enabled (cfg.effect_enabled),
        .cmd            (cmd)
    );

    sfd_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd       (cmd),
        .left_in   (left_in),
        .right_in  (right_in),
        .left_out  (left_out),
        .right_out (right_out)
    );

`ifndef ASSERT_OFF
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while an item is in flight");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid || !out_stall))
        else $error("waiting result overwritten");

    a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall) |=> (!out_valid || $past(cmd.load_out)))
        else $error("result delivered twice");
`endif

endmodule

`default_nettype wire
